// ----- rtl/lru_cache_with_ttl_unit_assert.svh -----
// assertion macros for the lru cache checker
`ifndef LRU_CACHE_WITH_TTL_UNIT_ASSERT_SVH
`define LRU_CACHE_WITH_TTL_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru cache check failed");

// next-cycle implication, checked outside reset
`define LCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru cache check failed");

`endif

// ----- rtl/lct_pkg.sv -----
`timescale 1ns / 1ps

package lct_pkg;

    // cache geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int FR_W    = IDX_W + 1;

    // field widths
    localparam int OFFSET_W = 40;
    localparam int COUNT_W  = 20;
    localparam int KEY_W    = OFFSET_W + COUNT_W;
    localparam int HANDLE_W = 16;
    localparam int TICK_W   = 32;
    localparam int CNT_W    = 32;
    localparam int OP_W     = 2;
    localparam int IN_W     = 112;
    localparam int OUT_W    = 80;

    localparam logic [TICK_W-1:0] TTL_RESET = TICK_W'(1000);

    // operation bit that selects invalidate, and the insert code bit
    localparam int OP_CLEAR_BIT  = 1;
    localparam int OP_INSERT_BIT = 0;

    typedef enum logic [2:0] {
        ST_HIT         = 3'd0,
        ST_MISS        = 3'd1,
        ST_EXPIRED     = 3'd2,
        ST_INSERTED    = 3'd3,
        ST_REFRESHED   = 3'd4,
        ST_EVICTED     = 3'd5,
        ST_INVALIDATED = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_MATCH  = 2'd1,
        S_AGE    = 2'd2,
        S_COMMIT = 2'd3
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic match;
        logic age;
        logic commit;
    } t_cmd;

endpackage

// ----- rtl/lct_datapath.sv -----
`timescale 1ns / 1ps

module lct_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lct_pkg::t_cmd                    i_cmd,
    input  logic [lct_pkg::OP_W-1:0]         i_op,
    input  logic [lct_pkg::IN_W-1:0]         i_word,
    input  logic                             i_cfg_we,
    input  logic [lct_pkg::TICK_W-1:0]       i_cfg_data,
    output logic [2:0]                       o_status,
    output logic [lct_pkg::OUT_W-1:0]        o_word
);

    // captured request
    logic [lct_pkg::OP_W-1:0]     r_op;
    logic [lct_pkg::KEY_W-1:0]    r_key;
    logic [lct_pkg::HANDLE_W-1:0] r_handle;
    logic [lct_pkg::TICK_W-1:0]   r_now;
    logic [lct_pkg::TICK_W-1:0]   r_ttl;

    // entry store
    logic                         r_valid  [lct_pkg::ENTRIES];
    logic [lct_pkg::RANK_W-1:0]   r_rank   [lct_pkg::ENTRIES];
    logic [lct_pkg::KEY_W-1:0]    r_keys   [lct_pkg::ENTRIES];
    logic [lct_pkg::TICK_W-1:0]   r_stamp  [lct_pkg::ENTRIES];
    logic [lct_pkg::HANDLE_W-1:0] r_hdl    [lct_pkg::ENTRIES];

    // match stage results
    logic                         r_hit;
    logic [lct_pkg::IDX_W-1:0]    r_hit_idx;
    logic [lct_pkg::IDX_W-1:0]    r_new_idx;
    logic                         r_full;

    // age stage results
    logic                         r_expired;
    logic [lct_pkg::HANDLE_W-1:0] r_hit_hdl;
    logic [lct_pkg::RANK_W-1:0]   r_hit_rank;

    // counters and result
    logic [lct_pkg::CNT_W-1:0]    r_hit_cnt;
    logic [lct_pkg::CNT_W-1:0]    r_miss_cnt;
    lct_pkg::t_status             r_out_status;
    logic [lct_pkg::HANDLE_W-1:0] r_out_hdl;

    logic                         n_hit;
    logic [lct_pkg::IDX_W-1:0]    n_hit_idx;
    logic [lct_pkg::IDX_W-1:0]    n_free_idx;
    logic [lct_pkg::IDX_W-1:0]    n_victim_idx;
    logic                         n_full;

    logic                         n_valid  [lct_pkg::ENTRIES];
    logic [lct_pkg::RANK_W-1:0]   n_rank   [lct_pkg::ENTRIES];
    logic [lct_pkg::CNT_W-1:0]    n_hit_cnt;
    logic [lct_pkg::CNT_W-1:0]    n_miss_cnt;
    lct_pkg::t_status             n_status;
    logic [lct_pkg::HANDLE_W-1:0] n_out_hdl;
    logic                         n_wr;
    logic [lct_pkg::IDX_W-1:0]    n_slot;
    logic [lct_pkg::FR_W-1:0]     n_front;
    logic                         n_do_front;
    logic                         n_do_remove;
    logic [lct_pkg::TICK_W-1:0]   n_age;

    // ttl register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= lct_pkg::TTL_RESET;
        end else if (i_cfg_we) begin
            r_ttl <= i_cfg_data;
        end
    end

    // request capture, tdata is offset, count, handle, now from bit 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_key    <= i_word[lct_pkg::KEY_W-1:0];
            r_handle <= i_word[lct_pkg::KEY_W +: lct_pkg::HANDLE_W];
            r_now    <= i_word[lct_pkg::KEY_W + lct_pkg::HANDLE_W +: lct_pkg::TICK_W];
        end
    end

    // parallel tag compare, free slot and lru slot search
    always_comb begin
        n_hit        = 1'b0;
        n_hit_idx    = '0;
        n_free_idx   = '0;
        n_victim_idx = '0;
        n_full       = 1'b1;
        for (int i = lct_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_keys[i] == r_key)) begin
                n_hit     = 1'b1;
                n_hit_idx = lct_pkg::IDX_W'(i);
            end
            if (!r_valid[i]) begin
                n_full     = 1'b0;
                n_free_idx = lct_pkg::IDX_W'(i);
            end
            if (r_valid[i] && (r_rank[i] == lct_pkg::RANK_W'(lct_pkg::ENTRIES - 1))) begin
                n_victim_idx = lct_pkg::IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            r_hit     <= n_hit;
            r_hit_idx <= n_hit_idx;
            r_full    <= n_full;
            r_new_idx <= n_full ? n_victim_idx : n_free_idx;
        end
    end

    // age of the matched entry against the ttl
    assign n_age = r_now - r_stamp[r_hit_idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.age) begin
            r_expired  <= (n_age > r_ttl);
            r_hit_hdl  <= r_hdl[r_hit_idx];
            r_hit_rank <= r_rank[r_hit_idx];
        end
    end

    // operation decode and recency update
    always_comb begin
        n_hit_cnt   = r_hit_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_out_hdl   = '0;
        n_wr        = 1'b0;
        n_slot      = r_hit_idx;
        n_front     = {1'b0, r_hit_rank};
        n_do_front  = 1'b0;
        n_do_remove = 1'b0;
        n_status    = lct_pkg::ST_INVALIDATED;
        if (r_op[lct_pkg::OP_CLEAR_BIT]) begin
            n_status = lct_pkg::ST_INVALIDATED;
        end else if (!r_op[lct_pkg::OP_INSERT_BIT]) begin
            if (!r_hit) begin
                n_status   = lct_pkg::ST_MISS;
                n_miss_cnt = r_miss_cnt + 1'b1;
            end else if (r_expired) begin
                n_status    = lct_pkg::ST_EXPIRED;
                n_miss_cnt  = r_miss_cnt + 1'b1;
                n_do_remove = 1'b1;
            end else begin
                n_status   = lct_pkg::ST_HIT;
                n_hit_cnt  = r_hit_cnt + 1'b1;
                n_out_hdl  = r_hit_hdl;
                n_do_front = 1'b1;
            end
        end else begin
            n_wr       = 1'b1;
            n_do_front = 1'b1;
            if (r_hit) begin
                n_status = lct_pkg::ST_REFRESHED;
            end else begin
                // new entry: every other valid entry ages by one
                n_slot   = r_new_idx;
                n_front  = lct_pkg::FR_W'(lct_pkg::ENTRIES);
                n_status = r_full ? lct_pkg::ST_EVICTED : lct_pkg::ST_INSERTED;
            end
        end

        for (int i = 0; i < lct_pkg::ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_rank[i]  = r_rank[i];
            if (r_op[lct_pkg::OP_CLEAR_BIT]) begin
                n_valid[i] = 1'b0;
                n_rank[i]  = '0;
            end else if (n_slot == lct_pkg::IDX_W'(i)) begin
                if (n_do_remove) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end else if (n_do_front) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end
            end else if (r_valid[i]) begin
                if (n_do_front && ({1'b0, r_rank[i]} < n_front)) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end else if (n_do_remove && ({1'b0, r_rank[i]} > n_front)) begin
                    n_rank[i] = r_rank[i] - 1'b1;
                end
            end
        end
    end

    // commit of valid bits, ranks and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lct_pkg::ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else if (i_cmd.commit) begin
            for (int i = 0; i < lct_pkg::ENTRIES; i++) begin
                r_valid[i] <= n_valid[i];
                r_rank[i]  <= n_rank[i];
            end
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    // entry payload write and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (n_wr) begin
                r_keys[n_slot]  <= r_key;
                r_stamp[n_slot] <= r_now;
                r_hdl[n_slot]   <= r_handle;
            end
            r_out_status <= n_status;
            r_out_hdl    <= n_out_hdl;
        end
    end

    assign o_status = r_out_status;
    assign o_word   = {r_miss_cnt, r_hit_cnt, r_out_hdl};

endmodule

// ----- rtl/lct_ctrl.sv -----
`timescale 1ns / 1ps

module lct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output lct_pkg::t_cmd o_cmd
);

    lct_pkg::t_state r_state;
    lct_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_slot_free;

    // result slot can take a new word this cycle
    assign w_slot_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lct_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = lct_pkg::S_MATCH;
                end
            end
            lct_pkg::S_MATCH:  n_state = lct_pkg::S_AGE;
            lct_pkg::S_AGE:    n_state = lct_pkg::S_COMMIT;
            lct_pkg::S_COMMIT: begin
                if (w_slot_free) begin
                    n_state = lct_pkg::S_IDLE;
                end
            end
            default:           n_state = lct_pkg::S_IDLE;
        endcase
    end

    // outputs and commands
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            lct_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            lct_pkg::S_MATCH: o_cmd.match = 1'b1;
            lct_pkg::S_AGE:   o_cmd.age   = 1'b1;
            lct_pkg::S_COMMIT: begin
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lct_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/lru_cache_with_ttl_unit.sv -----
// lru cache with time to live
// slave stream takes one request word: tuser is the operation (lookup,
// insert or refresh, invalidate all), tdata carries the 60-bit key as
// offset and count, the data handle and the current tick stamp.
// master stream returns one result word per request: tuser is the status,
// tdata the hit handle and the running hit and miss totals.
// the cfg channel writes the ttl in ticks and is always ready; write it
// only while no request is in flight.
// result valid rises at the commit that ends each request: the accept edge
// captures, then a parallel tag match over all entries, the age check of
// the matched entry and the commit of ranks, valid bits and counters. a new
// request is taken only after the previous one has committed.
// reset empties the cache, zeroes both totals and sets the ttl to 1000.
// when the receiver stalls the result holds; the next request is still
// accepted and worked up to its commit, which waits for the result slot.
`timescale 1ns / 1ps

module lru_cache_with_ttl_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // batch_offset, batch_count, data_handle, now_ticks, zero fill
    input  logic [lct_pkg::IN_W-1:0]     i_s_axis_tdata,
    // operation
    input  logic [lct_pkg::OP_W-1:0]     i_s_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // hit_data_handle, hit_total, miss_total
    output logic [lct_pkg::OUT_W-1:0]    o_m_axis_tdata,
    // status
    output logic [2:0]                   o_m_axis_tuser,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lct_pkg::TICK_W-1:0]   i_cfg_data
);

    lct_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    // sequencing
    lct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // entry store and update logic
    lct_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_op       (i_s_axis_tuser),
        .i_word     (i_s_axis_tdata),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_status   (o_m_axis_tuser),
        .o_word     (o_m_axis_tdata)
    );

endmodule

// ----- rtl/lct_checker.sv -----
`timescale 1ns / 1ps
`include "lru_cache_with_ttl_unit_assert.svh"

module lct_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       i_s_tready,
    input logic                       i_m_tvalid,
    input logic                       i_m_tready,
    input logic [lct_pkg::OUT_W-1:0]  i_m_tdata,
    input logic [2:0]                 i_m_tuser
);

    // only defined status codes leave the block
    `LCT_ASSERT_NOW(a_status_code, i_m_tvalid, i_m_tuser <= lct_pkg::ST_INVALIDATED)

    // the handle field is zero unless the word reports a hit
    `LCT_ASSERT_NOW(a_handle_zero, i_m_tvalid && (i_m_tuser != lct_pkg::ST_HIT), i_m_tdata[lct_pkg::HANDLE_W-1:0] == '0)

    // one request at a time: input closes right after an accept
    `LCT_ASSERT_NEXT(a_one_in_flight, i_s_tvalid && i_s_tready, !i_s_tready)

    // a stalled result holds
    `LCT_ASSERT_NEXT(a_stall_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))

endmodule

bind lru_cache_with_ttl_unit lct_checker u_lct_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

// ----- tb/sv/lct_reply_check.sv -----
`timescale 1ns / 1ps

module lct_reply_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    // batch_offset, batch_count, data_handle, now_ticks, zero fill
    input  logic [lct_pkg::IN_W-1:0]   i_req_data,
    // operation
    input  logic [lct_pkg::OP_W-1:0]   i_req_user,
    input  logic                       i_rsp_valid,
    input  logic                       i_rsp_ready,
    // hit_data_handle, hit_total, miss_total
    input  logic [lct_pkg::OUT_W-1:0]  i_rsp_data,
    // status
    input  logic [2:0]                 i_rsp_user,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [lct_pkg::TICK_W-1:0] i_cfg_data,
    output int                         o_mismatches,
    output int                         o_outstanding
);
    import lct_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    hits;
        logic [CNT_W-1:0]    misses;
    } t_reply;

    // shadow copy of the cache
    logic [TICK_W-1:0]   ttl_q;
    logic                line_valid  [ENTRIES];
    logic [KEY_W-1:0]    line_key    [ENTRIES];
    logic [TICK_W-1:0]   line_stamp  [ENTRIES];
    logic [HANDLE_W-1:0] line_handle [ENTRIES];
    logic [RANK_W-1:0]   line_rank   [ENTRIES];
    logic [CNT_W-1:0]    hit_cnt;
    logic [CNT_W-1:0]    miss_cnt;

    // replies still owed by the block, oldest first
    t_reply replies[$];
    int     mismatch_cnt = 0;

    function automatic int find_line(input logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && line_key[i] == key)
                return i;
        return -1;
    endfunction

    // move a line to most recently used
    function automatic void promote(input int s);
        logic [RANK_W-1:0] r;
        r = line_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && line_rank[i] < r)
                line_rank[i] = line_rank[i] + 1'b1;
        line_rank[s] = '0;
    endfunction

    // drop a line, closing the gap in the recency order
    function automatic void drop(input int s);
        logic [RANK_W-1:0] r;
        r = line_rank[s];
        line_valid[s] = 1'b0;
        line_rank[s]  = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && line_rank[i] > r)
                line_rank[i] = line_rank[i] - 1'b1;
    endfunction

    function automatic void clear_lines();
        for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_rank[i]  = '0;
        end
    endfunction

    // apply one request to the shadow cache and build its reply
    function automatic t_reply cache_access(
        input logic [OP_W-1:0]     op,
        input logic [KEY_W-1:0]    key,
        input logic [HANDLE_W-1:0] handle,
        input logic [TICK_W-1:0]   now
    );
        t_reply            res;
        int                s;
        int                slot;
        logic [TICK_W-1:0] age;
        res = '0;
        if (op[OP_CLEAR_BIT]) begin
            clear_lines();
            res.status = ST_INVALIDATED;
        end else if (!op[OP_INSERT_BIT]) begin
            s = find_line(key);
            if (s < 0) begin
                miss_cnt   = miss_cnt + 1'b1;
                res.status = ST_MISS;
            end else begin
                age = now - line_stamp[s];
                if (age > ttl_q) begin
                    drop(s);
                    miss_cnt   = miss_cnt + 1'b1;
                    res.status = ST_EXPIRED;
                end else begin
                    promote(s);
                    hit_cnt    = hit_cnt + 1'b1;
                    res.handle = line_handle[s];
                    res.status = ST_HIT;
                end
            end
        end else begin
            s = find_line(key);
            if (s >= 0) begin
                line_handle[s] = handle;
                line_stamp[s]  = now;
                promote(s);
                res.status = ST_REFRESHED;
            end else begin
                slot = -1;
                res.status = ST_INSERTED;
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!line_valid[i])
                        slot = i;
                // full: evict the least recently used line
                if (slot < 0) begin
                    slot = 0;
                    for (int i = 1; i < ENTRIES; i++)
                        if (line_rank[i] > line_rank[slot])
                            slot = i;
                    drop(slot);
                    res.status = ST_EVICTED;
                end
                for (int i = 0; i < ENTRIES; i++)
                    if (line_valid[i])
                        line_rank[i] = line_rank[i] + 1'b1;
                line_valid[slot]  = 1'b1;
                line_key[slot]    = key;
                line_stamp[slot]  = now;
                line_handle[slot] = handle;
                line_rank[slot]   = '0;
            end
        end
        res.hits   = hit_cnt;
        res.misses = miss_cnt;
        return res;
    endfunction

    // watch the three channels
    always @(posedge i_clk) begin : watch
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            clear_lines();
            ttl_q    = TTL_RESET;
            hit_cnt  = '0;
            miss_cnt = '0;
            replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                ttl_q = i_cfg_data;
            if (i_req_valid && i_req_ready)
                replies.insert(replies.size(),
                               cache_access(i_req_user,
                                            i_req_data[0 +: KEY_W],
                                            i_req_data[KEY_W +: HANDLE_W],
                                            i_req_data[KEY_W+HANDLE_W +: TICK_W]));
            if (i_rsp_valid && i_rsp_ready) begin
                got.status = t_status'(i_rsp_user);
                got.handle = i_rsp_data[0 +: HANDLE_W];
                got.hits   = i_rsp_data[HANDLE_W +: CNT_W];
                got.misses = i_rsp_data[HANDLE_W+CNT_W +: CNT_W];
                if (replies.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("%0t: reply word with none pending: status %0d handle %h",
                                 $time, got.status, got.handle);
                end else begin
                    want = replies.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT) begin
                            $write("%0t: reply mismatch (expected/actual) status %0d/%0d",
                                   $time, want.status, got.status);
                            $display(" handle %h/%h hits %0d/%0d misses %0d/%0d",
                                     want.handle, got.handle, want.hits, got.hits,
                                     want.misses, got.misses);
                        end
                    end
                end
            end
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= replies.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lct_pkg::*;

    localparam logic [OP_W-1:0] OP_LOOKUP    = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR_ALT = 2'd3;

    localparam int POOL_SIZE     = 24;
    localparam int HOLD_CYCLES   = 80;
    localparam int REPLY_LATENCY = 4;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [IN_W-1:0]     i_s_axis_tdata;
    logic [OP_W-1:0]     i_s_axis_tuser;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [OUT_W-1:0]    o_m_axis_tdata;
    logic [2:0]          o_m_axis_tuser;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [TICK_W-1:0]   i_cfg_data;

    int                  mismatches;
    int                  outstanding;
    int                  tx_idle_pct = 30;
    int                  rx_idle_pct = 76;
    logic                rx_hold_req = 1'b0;
    logic [TICK_W-1:0]   tick_now;
    logic [KEY_W-1:0]    key_pool [POOL_SIZE];

    lru_cache_with_ttl_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    lct_reply_check cache_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .i_req_ready   (o_s_axis_tready),
        .i_req_data    (i_s_axis_tdata),
        .i_req_user    (i_s_axis_tuser),
        .i_rsp_valid   (o_m_axis_tvalid),
        .i_rsp_ready   (i_m_axis_tready),
        .i_rsp_data    (o_m_axis_tdata),
        .i_rsp_user    (o_m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                hold_left   = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [KEY_W-1:0] random_key();
        return KEY_W'({$urandom(), $urandom()});
    endfunction

    // offer one request word; entered and left at a falling edge
    task automatic send_request(
        input logic [OP_W-1:0]     op,
        input logic [KEY_W-1:0]    key,
        input logic [HANDLE_W-1:0] handle,
        input logic [TICK_W-1:0]   now
    );
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {{(IN_W-KEY_W-HANDLE_W-TICK_W){1'b0}}, now, handle, key};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // wait until every reply has come back
    task automatic wait_drained();
        @(negedge i_clk);
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (REPLY_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_ttl(input logic [TICK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly keys from a small pool so that hits, expiry and eviction all occur
    task automatic run_random(input int count);
        int                roll;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                op = OP_LOOKUP;
            else if (roll < 95)
                op = OP_INSERT;
            else if (roll < 98)
                op = OP_CLEAR;
            else
                op = OP_CLEAR_ALT;
            if ($urandom_range(0, 9) == 0)
                key = random_key();
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            // time steps: often none, mostly short, sometimes far
            roll = $urandom_range(0, 99);
            if (roll >= 95)
                tick_now = $urandom();
            else if (roll >= 80)
                tick_now = tick_now + $urandom_range(200, 2000);
            else if (roll >= 25)
                tick_now = tick_now + $urandom_range(1, 200);
            send_request(op, key, HANDLE_W'($urandom()), tick_now);
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [KEY_W-1:0] key_a;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_LOOKUP;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        tick_now        = $urandom();
        key_pool[0]     = '0;
        key_pool[1]     = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = random_key();
        key_a = random_key();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty miss, ttl edge, wrap-around age, refresh of an old entry
        send_request(OP_LOOKUP, '0, 16'h0000, 32'h0000_0000);
        send_request(OP_INSERT, '1, 16'hFFFF, 32'h0000_0000);
        send_request(OP_LOOKUP, '1, 16'h0000, 32'd1000);
        send_request(OP_LOOKUP, '1, 16'h0000, 32'd1001);
        send_request(OP_INSERT, key_a, 16'h1234, 32'hFFFF_FFF0);
        send_request(OP_LOOKUP, key_a, 16'h0000, 32'h0000_0010);
        send_request(OP_INSERT, key_a, 16'hABCD, 32'h7000_0000);
        send_request(OP_LOOKUP, key_a, 16'h0000, 32'h7000_0000);
        // fill the cache, then one more insert evicts the oldest line
        for (int i = 0; i < ENTRIES - 1; i++)
            send_request(OP_INSERT, {COUNT_W'(i * 7), OFFSET_W'(i + 1)},
                         HANDLE_W'(i), 32'h7000_0001 + i);
        send_request(OP_INSERT, {{COUNT_W{1'b1}}, {OFFSET_W{1'b0}}}, 16'h0000,
                     32'h7000_0100);
        send_request(OP_CLEAR, '0, 16'h0000, 32'h7000_0101);
        send_request(OP_CLEAR_ALT, '0, 16'h0000, 32'h7000_0102);
        i_s_axis_tvalid <= 1'b0;
        wait_drained();

        // phase 1: sender idles lightly, receiver heavily
        write_ttl(TICK_W'($urandom_range(300, 3000)));
        run_random(115);
        i_s_axis_tvalid <= 1'b0;
        wait_drained();
        run_random(115);
        i_s_axis_tvalid <= 1'b0;
        wait_drained();

        // phase 2: roles swapped, zero ttl so only same-tick lookups hit
        tx_idle_pct = 76;
        rx_idle_pct <= 30;
        write_ttl('0);
        send_request(OP_INSERT, key_pool[3], 16'h5A5A, tick_now);
        send_request(OP_LOOKUP, key_pool[3], 16'h0000, tick_now);
        send_request(OP_LOOKUP, key_pool[3], 16'h0000, tick_now + 1'b1);
        run_random(220);
        i_s_axis_tvalid <= 1'b0;
        wait_drained();

        // phase 3: no idling, largest ttl, one long receiver hold-off
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        write_ttl('1);
        run_random(100);
        rx_hold_req <= 1'b1;
        run_random(30);
        run_random(100);
        i_s_axis_tvalid <= 1'b0;
        wait_drained();

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
